/* hw/rtl/sbcs_pkg.sv */
// ----------------------------------------------------------------------------
// sbcs_pkg
// Shared types and constants for the serial bus computer side sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbcs_pkg;

    // Sequencer phases as they appear on the bus_phase output
    typedef enum logic [4:0] {
        PH_IDLE               = 5'd0,
        PH_CMD_START          = 5'd1,
        PH_CMD_LOW            = 5'd2,
        PH_CMD_FRAME          = 5'd3,
        PH_CMD_HIGH           = 5'd4,
        PH_CMD_ACK            = 5'd5,
        PH_CMD_ACK_BITS       = 5'd6,
        PH_PRE_COMPLETE       = 5'd7,
        PH_CMD_COMPLETE       = 5'd8,
        PH_CMD_COMPLETE_BITS  = 5'd9,
        PH_DATA_OUT           = 5'd10,
        PH_DATA_OUT_BITS      = 5'd11,
        PH_DATA_FRAME         = 5'd12,
        PH_DATA_ACK           = 5'd13,
        PH_DATA_ACK_BITS      = 5'd14,
        PH_DATA_PRE_COMPLETE  = 5'd15,
        PH_DATA_COMPLETE      = 5'd16,
        PH_DATA_COMPLETE_BITS = 5'd17
    } t_phase;

    // Input commands
    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_LOAD_BYTE  = 3'd1,
        CMD_CMD_FRAME  = 3'd2,
        CMD_EXECUTE    = 3'd3,
        CMD_DATA_FRAME = 3'd4,
        CMD_SET_LINE   = 3'd5
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BIT_PERIOD      = 3'd0,
        CFG_START_OFFSET    = 3'd1,
        CFG_CMD_LOW_DELAY   = 3'd2,
        CFG_FRAME_DELAY     = 3'd3,
        CFG_HIGH_DELAY      = 3'd4,
        CFG_ACK_WINDOW      = 3'd5,
        CFG_COMPLETE_WINDOW = 3'd6,
        CFG_DATA_OUT_WINDOW = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_W        = 24;
    localparam logic [9:0]  CMD_FRAME_LEN = 10'd5;
    localparam logic [3:0]  FRAME_BITS    = 4'd10;
    localparam logic [3:0]  RX_BITS       = 4'd9;
    localparam logic [9:0]  RX_MAX        = 10'd512;

    // Clamp a widened sum to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Zero-extend an unsigned value of up to 24 bits into the sum width
    function automatic logic signed [33:0] uext(input logic [23:0] v);
        uext = $signed({10'd0, v});
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/serial_bus_computer_side_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// serial_bus_computer_side_sequencer_unit
// Computer side of a serial peripheral bus: command timing, frame output,
// drive byte reception and answer reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transfer per event. tuser carries the command (tick,
//   load byte, command frame, execute, data frame, set line), tdata the
//   operands. Master stream: one transfer per accepted event with the line
//   level, command line, phase, answer, received byte and byte count. The user
//   writes timing registers via configuration port only while idle; not enforced.
// Latency and throughput:
//   One event per cycle while the receiver takes results. The result of an
//   event is on the master stream the cycle after it is accepted. The frame
//   byte for the next serial pattern is read from frame memory ahead of first use.
// Reset:
//   Synchronous, active low. Clears phase, counters and the result valid flag;
//   timing registers return to their defaults. Frame memory is not cleared.
// Stall:
//   The result register holds while the receiver stalls; a new event is
//   taken in the same cycle that the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bus_computer_side_sequencer_unit #(
    parameter int unsigned FRAME_DEPTH = 512,
    parameter logic [7:0]  ACK_CODE    = 8'd65
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire sbcs_pkg::t_cfg_idx      i_cfg_addr,
    input  wire logic [sbcs_pkg::CFG_W-1:0] i_cfg_wdata,
    // event stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tick_amount[15:0], frame_index[24:16], frame_byte[32:25],
    // frame_length[42:33], line_bit[43], line_enable[44], zero[47:45]
    input  wire logic [47:0]             s_axis_tdata,
    // command[2:0]
    input  wire logic [2:0]              s_axis_tuser,
    // result stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // data_to_drive[0], command_asserted[1], bus_phase[6:2], answer_valid[7],
    // answer_byte[15:8], rx_valid[16], rx_byte[24:17], rx_count[34:25],
    // zero[39:35]
    output logic [39:0]                  m_axis_tdata
);
    import sbcs_pkg::*;

    localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // input fields
    logic        w_acc;
    t_cmd        w_cmd;
    logic [15:0] w_tick;
    logic [8:0]  w_fidx;
    logic [7:0]  w_fbyte;
    logic [9:0]  w_flen;
    logic        w_lbit;
    logic        w_len;

    // configuration
    logic [15:0] r_bit_period;
    logic [15:0] r_start_offset;
    logic [19:0] r_cmd_low_delay;
    logic [19:0] r_frame_delay;
    logic [19:0] r_high_delay;
    logic [19:0] r_ack_window;
    logic [23:0] r_complete_window;
    logic [19:0] r_data_out_window;

    // sequencer state
    t_phase             r_phase,     n_phase;
    logic signed [31:0] r_cd,        n_cd;
    logic [9:0]         r_remain,    n_remain;
    logic [9:0]         r_flen,      n_flen;
    logic [3:0]         r_pos,       n_pos;
    logic               r_line_out,  n_line_out;
    logic               r_line_in,   n_line_in;
    logic               r_drv_en,    n_drv_en;
    logic               r_cmd_lvl,   n_cmd_lvl;
    logic [3:0]         r_bits_left, n_bits_left;
    logic [7:0]         r_rx_shift,  n_rx_shift;
    logic               r_rx_done,   n_rx_done;
    logic [7:0]         r_answer,    n_answer;
    logic               r_ans_ok,    n_ans_ok;
    logic [7:0]         r_status,    n_status;
    logic [9:0]         r_rx_total,  n_rx_total;
    logic               n_rxv;
    logic [7:0]         n_rxb;

    // frame memory
    logic [7:0]    r_mem [FRAME_DEPTH];
    logic [7:0]    r_rd;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [12:0]   w_rd_off;
    logic [12:0]   w_wr_off;
    logic          w_wr_en;

    // datapath helpers
    logic signed [31:0] w_cdm;
    logic signed [31:0] w_cdm_bp;
    logic signed [31:0] w_start_cd;
    logic               w_byte_stop;
    logic               w_byte_end;
    logic signed [31:0] w_byte_base;
    logic signed [31:0] w_base_bp;
    logic signed [31:0] w_base_dow;
    logic [9:0]         w_pattern;
    logic [3:0]         w_pos_inc;
    logic               w_start_seen;
    logic               w_bits_phase;
    logic               w_frame_run;

    // output register
    logic        r_ovalid;
    logic [39:0] r_odata;

    // unpack the event
    assign w_cmd   = t_cmd'(s_axis_tuser);
    assign w_tick  = s_axis_tdata[15:0];
    assign w_fidx  = s_axis_tdata[24:16];
    assign w_fbyte = s_axis_tdata[32:25];
    assign w_flen  = s_axis_tdata[42:33];
    assign w_lbit  = s_axis_tdata[43];
    assign w_len   = s_axis_tdata[44];

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period      <= 16'd94;
            r_start_offset    <= 16'd47;
            r_cmd_low_delay   <= 20'd1000;
            r_frame_delay     <= 20'd1000;
            r_high_delay      <= 20'd1000;
            r_ack_window      <= 20'd20000;
            r_complete_window <= 24'd200000;
            r_data_out_window <= 20'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BIT_PERIOD:      r_bit_period      <= i_cfg_wdata[15:0];
                CFG_START_OFFSET:    r_start_offset    <= i_cfg_wdata[15:0];
                CFG_CMD_LOW_DELAY:   r_cmd_low_delay   <= i_cfg_wdata[19:0];
                CFG_FRAME_DELAY:     r_frame_delay     <= i_cfg_wdata[19:0];
                CFG_HIGH_DELAY:      r_high_delay      <= i_cfg_wdata[19:0];
                CFG_ACK_WINDOW:      r_ack_window      <= i_cfg_wdata[19:0];
                CFG_COMPLETE_WINDOW: r_complete_window <= i_cfg_wdata[23:0];
                CFG_DATA_OUT_WINDOW: r_data_out_window <= i_cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    // countdown arithmetic
    assign w_cdm      = sat32($signed({{2{r_cd[31]}}, r_cd}) - uext({8'd0, w_tick}));
    assign w_cdm_bp   = sat32($signed({{2{w_cdm[31]}}, w_cdm}) + uext({8'd0, r_bit_period}));
    assign w_start_cd = $signed({15'd0, ({1'b0, r_bit_period} + {1'b0, r_start_offset})});

    // drive byte reception window
    assign w_byte_stop = r_rx_done || !r_drv_en;
    assign w_byte_end  = w_byte_stop || (w_cdm <= 32'sd0);
    assign w_byte_base = w_byte_stop ? r_cd : w_cdm;
    assign w_base_bp   = sat32($signed({{2{w_byte_base[31]}}, w_byte_base})
                               + uext({8'd0, r_bit_period}));
    assign w_base_dow  = sat32($signed({{2{w_byte_base[31]}}, w_byte_base})
                               + uext({4'd0, r_data_out_window}));

    assign w_pattern    = {1'b0, ~r_rd, 1'b1};
    assign w_pos_inc    = r_pos + 4'd1;
    assign w_start_seen = !r_line_in && r_drv_en;
    assign w_frame_run  = r_pos < FRAME_BITS;
    assign w_bits_phase = (r_phase == PH_CMD_ACK_BITS) || (r_phase == PH_CMD_COMPLETE_BITS)
                       || (r_phase == PH_DATA_OUT_BITS) || (r_phase == PH_DATA_ACK_BITS)
                       || (r_phase == PH_DATA_COMPLETE_BITS);

    // next state of the sequencer for the accepted event
    always_comb begin
        n_phase     = r_phase;
        n_cd        = r_cd;
        n_remain    = r_remain;
        n_flen      = r_flen;
        n_pos       = r_pos;
        n_line_out  = r_line_out;
        n_line_in   = r_line_in;
        n_drv_en    = r_drv_en;
        n_cmd_lvl   = r_cmd_lvl;
        n_bits_left = r_bits_left;
        n_rx_shift  = r_rx_shift;
        n_rx_done   = r_rx_done;
        n_answer    = r_answer;
        n_ans_ok    = r_ans_ok;
        n_status    = r_status;
        n_rx_total  = r_rx_total;
        n_rxv       = 1'b0;
        n_rxb       = 8'd0;
        w_rd_en     = 1'b0;
        w_rd_off    = 13'd0;
        w_wr_en     = 1'b0;
        w_wr_off    = {4'd0, w_fidx};
        case (w_cmd)
            CMD_TICK: begin
                case (r_phase)
                    PH_CMD_START: begin
                        n_cd = w_cdm;
                        if (w_cdm <= 32'sd0) begin
                            n_phase    = PH_CMD_LOW;
                            n_cd       = $signed({12'd0, r_frame_delay});
                            n_cmd_lvl  = 1'b1;
                            n_line_out = 1'b0;
                            n_rx_total = 10'd0;
                        end
                    end
                    PH_CMD_LOW: begin
                        n_cd = w_cdm;
                        if (w_cdm <= 32'sd0) begin
                            // start the frame: first byte is at store offset zero
                            n_phase    = PH_CMD_FRAME;
                            n_cd       = w_cdm_bp;
                            w_rd_en    = 1'b1;
                            w_rd_off   = 13'd0;
                            n_remain   = (r_flen != 10'd0) ? r_flen - 10'd1 : 10'd0;
                            n_line_out = 1'b1;
                            n_pos      = 4'd1;
                        end
                    end
                    PH_CMD_FRAME, PH_DATA_FRAME: begin
                        if (w_frame_run) begin
                            n_cd = w_cdm;
                            if (w_cdm <= 32'sd0) begin
                                n_cd       = w_cdm_bp;
                                n_line_out = w_pattern[r_pos];
                                n_pos      = w_pos_inc;
                                if (w_pos_inc == FRAME_BITS && r_remain != 10'd0) begin
                                    // fetch the next byte of the frame
                                    w_rd_en  = 1'b1;
                                    w_rd_off = {3'd0, r_flen - r_remain};
                                    n_remain = r_remain - 10'd1;
                                    n_pos    = 4'd0;
                                end
                            end
                        end
                        if (!w_frame_run || (w_cdm <= 32'sd0 && w_pos_inc == FRAME_BITS
                                             && r_remain == 10'd0)) begin
                            if (r_phase == PH_CMD_FRAME) begin
                                n_phase = PH_CMD_HIGH;
                                n_cd    = $signed({12'd0, r_high_delay});
                            end else begin
                                n_phase = PH_DATA_ACK;
                                n_cd    = $signed({12'd0, r_ack_window});
                            end
                        end
                    end
                    PH_CMD_HIGH: begin
                        n_cd = w_cdm;
                        if (w_cdm <= 32'sd0) begin
                            n_phase   = PH_CMD_ACK;
                            n_cd      = $signed({12'd0, r_ack_window});
                            n_cmd_lvl = 1'b0;
                        end
                    end
                    PH_CMD_ACK, PH_CMD_COMPLETE, PH_DATA_ACK, PH_DATA_COMPLETE,
                    PH_DATA_OUT: begin
                        if (w_start_seen) begin
                            n_remain    = 10'd0;
                            n_bits_left = RX_BITS;
                            n_rx_shift  = 8'd0;
                            n_rx_done   = 1'b0;
                            n_cd        = w_start_cd;
                            n_phase     = t_phase'(r_phase + 5'd1);
                        end else begin
                            n_cd = w_cdm;
                            if (w_cdm <= 32'sd0) begin
                                if (r_phase == PH_DATA_OUT) begin
                                    n_answer = r_status;
                                    n_ans_ok = 1'b1;
                                end
                                n_phase = PH_IDLE;
                                n_cd    = 32'sd0;
                            end
                        end
                    end
                    PH_CMD_ACK_BITS: begin
                        n_cd = w_byte_base;
                        if (w_byte_end) begin
                            n_cd     = (r_rx_shift == ACK_CODE) ? w_base_bp : 32'sd0;
                            n_answer = r_rx_shift;
                            n_ans_ok = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end
                    PH_PRE_COMPLETE, PH_DATA_PRE_COMPLETE: begin
                        n_cd = w_cdm;
                        if (w_cdm <= 32'sd0) begin
                            n_phase = t_phase'(r_phase + 5'd1);
                            n_cd    = $signed({8'd0, r_complete_window});
                        end
                    end
                    PH_CMD_COMPLETE_BITS: begin
                        n_cd = w_byte_base;
                        if (w_byte_end) begin
                            n_status = r_rx_shift;
                            n_phase  = PH_DATA_OUT;
                            n_cd     = $signed({12'd0, r_data_out_window});
                        end
                    end
                    PH_DATA_OUT_BITS: begin
                        n_cd = w_byte_base;
                        if (w_byte_end) begin
                            n_rxv = 1'b1;
                            n_rxb = r_rx_shift;
                            if (r_rx_total < RX_MAX) begin
                                n_rx_total = r_rx_total + 10'd1;
                            end
                            n_phase = PH_DATA_OUT;
                            n_cd    = w_base_dow;
                        end
                    end
                    PH_DATA_ACK_BITS: begin
                        n_cd = w_byte_base;
                        if (w_byte_end) begin
                            if (r_rx_shift == ACK_CODE) begin
                                n_phase = PH_DATA_PRE_COMPLETE;
                                n_cd    = w_base_bp;
                            end else begin
                                n_answer = r_rx_shift;
                                n_ans_ok = 1'b1;
                                n_phase  = PH_IDLE;
                                n_cd     = 32'sd0;
                            end
                        end
                    end
                    PH_DATA_COMPLETE_BITS: begin
                        n_cd = w_byte_base;
                        if (w_byte_end) begin
                            n_answer = r_rx_shift;
                            n_ans_ok = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_cd    = 32'sd0;
                    end
                endcase
            end
            CMD_LOAD_BYTE: begin
                w_wr_en = (w_wr_off < 13'(FRAME_DEPTH));
            end
            CMD_CMD_FRAME: begin
                n_flen    = CMD_FRAME_LEN;
                n_phase   = PH_CMD_START;
                n_cd      = $signed({12'd0, r_cmd_low_delay});
                n_cmd_lvl = 1'b0;
                n_ans_ok  = 1'b0;
                n_answer  = 8'd0;
            end
            CMD_EXECUTE: begin
                n_phase   = PH_PRE_COMPLETE;
                n_cmd_lvl = 1'b0;
                n_ans_ok  = 1'b0;
                n_answer  = 8'd0;
            end
            CMD_DATA_FRAME: begin
                n_flen     = w_flen;
                n_phase    = PH_DATA_FRAME;
                w_rd_en    = 1'b1;
                w_rd_off   = 13'd0;
                n_remain   = (w_flen != 10'd0) ? w_flen - 10'd1 : 10'd0;
                n_line_out = 1'b1;
                n_pos      = 4'd1;
                n_cd       = $signed({16'd0, r_bit_period});
                n_cmd_lvl  = 1'b0;
                n_ans_ok   = 1'b0;
                n_answer   = 8'd0;
            end
            CMD_SET_LINE: begin
                n_drv_en = w_len;
                if (w_bits_phase && !r_rx_done && r_bits_left != 4'd0) begin
                    // shift in one bit, the last edge of the byte is the stop bit
                    n_cd        = w_start_cd;
                    n_bits_left = r_bits_left - 4'd1;
                    if (r_bits_left != 4'd1) begin
                        n_rx_shift = {w_lbit, r_rx_shift[7:1]};
                    end else begin
                        n_rx_done = 1'b1;
                    end
                end
                n_line_in = w_lbit;
            end
            default: ;
        endcase
    end

    assign w_rd_addr = w_rd_off[AW-1:0];

    // frame memory: write on load, read one byte ahead of use
    always_ff @(posedge i_clk) begin
        if (w_acc && w_wr_en) begin
            r_mem[w_wr_off[AW-1:0]] <= w_fbyte;
        end
        if (w_acc && w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cd        <= 32'sd0;
            r_remain    <= 10'd0;
            r_flen      <= 10'd0;
            r_pos       <= 4'd0;
            r_line_out  <= 1'b0;
            r_line_in   <= 1'b1;
            r_drv_en    <= 1'b0;
            r_cmd_lvl   <= 1'b0;
            r_bits_left <= 4'd0;
            r_rx_shift  <= 8'd0;
            r_rx_done   <= 1'b0;
            r_answer    <= 8'd0;
            r_ans_ok    <= 1'b0;
            r_status    <= 8'd0;
            r_rx_total  <= 10'd0;
        end else if (w_acc) begin
            r_phase     <= n_phase;
            r_cd        <= n_cd;
            r_remain    <= n_remain;
            r_flen      <= n_flen;
            r_pos       <= n_pos;
            r_line_out  <= n_line_out;
            r_line_in   <= n_line_in;
            r_drv_en    <= n_drv_en;
            r_cmd_lvl   <= n_cmd_lvl;
            r_bits_left <= n_bits_left;
            r_rx_shift  <= n_rx_shift;
            r_rx_done   <= n_rx_done;
            r_answer    <= n_answer;
            r_ans_ok    <= n_ans_ok;
            r_status    <= n_status;
            r_rx_total  <= n_rx_total;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_acc) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_odata <= {5'd0, n_rx_total, n_rxb, n_rxv,
                        (n_ans_ok ? n_answer : 8'd0), n_ans_ok,
                        n_phase, n_cmd_lvl, n_line_out};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    a_cmd_line_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_lvl |-> (r_phase == PH_CMD_LOW || r_phase == PH_CMD_FRAME
                       || r_phase == PH_CMD_HIGH))
        else $error("command line active outside command timing phases");
    a_bit_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_BITS)
        else $error("frame bit position out of range");
    a_rx_total_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_total <= RX_MAX)
        else $error("received byte count past saturation");
    a_cmd_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == CMD_CMD_FRAME) |=> (r_phase == PH_CMD_START && !r_ans_ok))
        else $error("command frame did not start the sequence");
`endif

endmodule

`default_nettype wire
